[design/kdrc_pkg.sv]
// Shared constants and codes for the keyed decaying rate counters.
`default_nettype none

package kdrc_pkg;

    localparam int ENTRIES_DEF  = 16;
    localparam int KEY_BITS_DEF = 32;
    localparam int KEY_IN_W     = 32;
    localparam int FRAC_BITS    = 16;
    localparam int DECAY_BITS   = 16;
    localparam int COUNT_W      = 32;
    localparam int STAMP_W      = 32;

    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = DECAY_BITS + 1;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [COUNT_W-1:0]    COUNT_ONE = COUNT_W'(1) << FRAC_BITS;
    localparam logic [MUL_B_W-1:0]    DECAY_ONE = MUL_B_W'(1) << DECAY_BITS;
    localparam logic [DECAY_BITS-1:0] DECAY_RESET = DECAY_BITS'(32768);

    typedef enum logic [1:0] {
        OP_INC  = 2'd0,
        OP_READ = 2'd1,
        OP_TICK = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

endpackage

`default_nettype wire

[design/kdrc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module kdrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[design/kdrc_mul.sv]
// Shared unsigned multiplier used for every decay and scaling product.
`default_nettype none

module kdrc_mul (
    input  wire logic [kdrc_pkg::MUL_A_W-1:0] a,
    input  wire logic [kdrc_pkg::MUL_B_W-1:0] b,
    output logic      [kdrc_pkg::MUL_P_W-1:0] p
);

    assign p = kdrc_pkg::MUL_P_W'(a) * kdrc_pkg::MUL_P_W'(b);

endmodule

`default_nettype wire

[design/keyed_decaying_rate_counters.sv]
// Top level: table of keyed counters with exponential decay over elapsed ticks.
// A tick or an unused opcode gives its result in the cycle after the request.
// An increment or read reads and compares each searched entry in turn, then raises the decay
// factor to the elapsed time by square-and-multiply, scales the count and writes it back.
// Results appear on done for one cycle, busy falls with them, and the receiver cannot stall.
// Reset empties the table by clearing its fill count, zeroes time and sets decay_reg to 32768.
`default_nettype none

module keyed_decaying_rate_counters #(
    parameter int ENTRIES  = kdrc_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = kdrc_pkg::KEY_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [1:0]                         opcode,
    input  wire logic [kdrc_pkg::KEY_IN_W-1:0]      key,
    input  wire logic                               cfg_we,
    input  wire logic [kdrc_pkg::DECAY_BITS-1:0]    cfg_data,
    output logic                                    done,
    output logic [kdrc_pkg::COUNT_W-1:0]            count,
    output logic [1:0]                              status
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int FILL_W = $clog2(ENTRIES + 1);
    localparam int CW     = kdrc_pkg::COUNT_W;
    localparam int SW     = kdrc_pkg::STAMP_W;
    localparam int DW     = kdrc_pkg::DECAY_BITS;
    localparam int BW     = kdrc_pkg::MUL_B_W;
    localparam int RAM_W  = KEY_BITS + CW + SW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_MISS,
        S_POW,
        S_SQ,
        S_SCALE,
        S_FINISH
    } state_t;

    state_t                 state_reg, state_next;
    logic [DW-1:0]          decay_reg, decay_next;
    logic [SW-1:0]          seconds_reg, seconds_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [1:0]             op_reg, op_next;
    logic [KEY_BITS-1:0]    key_reg, key_next;
    logic [CW-1:0]          work_reg, work_next;
    logic [SW-1:0]          elapsed_reg, elapsed_next;
    logic [BW-1:0]          power_reg, power_next;
    logic [DW-1:0]          base_reg, base_next;
    logic                   done_reg, done_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [1:0]             status_reg, status_next;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [RAM_W-1:0]       ram_wdata;
    logic [RAM_W-1:0]       ram_rdata;
    logic [KEY_BITS-1:0]    rd_key;
    logic [CW-1:0]          rd_count;
    logic [SW-1:0]          rd_stamp;

    logic [kdrc_pkg::MUL_A_W-1:0] mul_a;
    logic [kdrc_pkg::MUL_B_W-1:0] mul_b;
    logic [kdrc_pkg::MUL_P_W-1:0] mul_p;

    logic [CW:0]            inc_sum;
    logic [CW-1:0]          inc_count;
    logic                   last_entry;

    kdrc_ram #(
        .WIDTH (RAM_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    kdrc_mul u_mul (
        .a (mul_a),
        .b (mul_b),
        .p (mul_p)
    );

    assign rd_key   = ram_rdata[RAM_W-1 -: KEY_BITS];
    assign rd_count = ram_rdata[CW+SW-1 -: CW];
    assign rd_stamp = ram_rdata[SW-1:0];

    assign inc_sum    = {1'b0, work_reg} + {1'b0, kdrc_pkg::COUNT_ONE};
    assign inc_count  = inc_sum[CW] ? {CW{1'b1}} : inc_sum[CW-1:0];
    assign last_entry = (FILL_W'(idx_reg) + FILL_W'(1)) == fill_reg;

    always_comb
    begin
        unique case (state_reg)
            S_POW:
            begin
                if (elapsed_reg[0])
                begin
                    mul_a = kdrc_pkg::MUL_A_W'(power_reg);
                    mul_b = BW'(base_reg);
                end
                else
                begin
                    mul_a = kdrc_pkg::MUL_A_W'(base_reg);
                    mul_b = BW'(base_reg);
                end
            end
            S_SQ:
            begin
                mul_a = kdrc_pkg::MUL_A_W'(base_reg);
                mul_b = BW'(base_reg);
            end
            default:
            begin
                mul_a = kdrc_pkg::MUL_A_W'(work_reg);
                mul_b = power_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        decay_next   = cfg_we ? cfg_data : decay_reg;
        seconds_next = seconds_reg;
        fill_next    = fill_reg;
        idx_next     = idx_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        work_next    = work_reg;
        elapsed_next = elapsed_reg;
        power_next   = power_reg;
        base_next    = base_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        status_next  = status_reg;
        ram_we       = 1'b0;
        ram_waddr    = idx_reg;
        ram_wdata    = {key_reg, work_reg, seconds_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next  = opcode;
                    key_next = KEY_BITS'(64'(key));
                    idx_next = '0;
                    unique case (opcode)
                        kdrc_pkg::OP_INC, kdrc_pkg::OP_READ:
                        begin
                            state_next = (fill_reg == '0) ? S_MISS : S_SCAN_RD;
                        end
                        kdrc_pkg::OP_TICK:
                        begin
                            seconds_next = seconds_reg + SW'(1);
                            done_next    = 1'b1;
                            count_next   = '0;
                            status_next  = kdrc_pkg::ST_OK;
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            count_next  = '0;
                            status_next = kdrc_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (rd_key == key_reg)
                begin
                    work_next    = rd_count;
                    elapsed_next = seconds_reg - rd_stamp;
                    power_next   = kdrc_pkg::DECAY_ONE;
                    base_next    = decay_reg;
                    state_next   = S_POW;
                end
                else if (last_entry)
                begin
                    state_next = S_MISS;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_MISS:
            begin
                done_next  = 1'b1;
                count_next = '0;
                state_next = S_IDLE;
                if (op_reg == kdrc_pkg::OP_READ)
                begin
                    status_next = kdrc_pkg::ST_NOT_FOUND;
                end
                else if (fill_reg == FILL_W'(ENTRIES))
                begin
                    status_next = kdrc_pkg::ST_FULL;
                end
                else
                begin
                    ram_we      = 1'b1;
                    ram_waddr   = fill_reg[IDX_W-1:0];
                    ram_wdata   = {key_reg, kdrc_pkg::COUNT_ONE, seconds_reg};
                    fill_next   = fill_reg + FILL_W'(1);
                    count_next  = kdrc_pkg::COUNT_ONE;
                    status_next = kdrc_pkg::ST_OK;
                end
            end
            S_POW:
            begin
                if (elapsed_reg == '0)
                begin
                    state_next = S_SCALE;
                end
                else if (elapsed_reg[0])
                begin
                    power_next = mul_p[DW+BW-1:DW];
                    state_next = S_SQ;
                end
                else
                begin
                    base_next    = mul_p[2*DW-1:DW];
                    elapsed_next = elapsed_reg >> 1;
                end
            end
            S_SQ:
            begin
                base_next    = mul_p[2*DW-1:DW];
                elapsed_next = elapsed_reg >> 1;
                state_next   = S_POW;
            end
            S_SCALE:
            begin
                work_next  = (mul_p[kdrc_pkg::MUL_P_W-1:CW+DW] != '0) ? {CW{1'b1}}
                                                                      : mul_p[CW+DW-1:DW];
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                ram_we      = 1'b1;
                ram_waddr   = idx_reg;
                done_next   = 1'b1;
                status_next = kdrc_pkg::ST_OK;
                state_next  = S_IDLE;
                if (op_reg == kdrc_pkg::OP_INC)
                begin
                    ram_wdata  = {key_reg, inc_count, seconds_reg};
                    count_next = inc_count;
                end
                else
                begin
                    ram_wdata  = {key_reg, work_reg, seconds_reg};
                    count_next = work_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            decay_reg   <= kdrc_pkg::DECAY_RESET;
            seconds_reg <= '0;
            fill_reg    <= '0;
            idx_reg     <= '0;
            op_reg      <= '0;
            key_reg     <= '0;
            work_reg    <= '0;
            elapsed_reg <= '0;
            power_reg   <= '0;
            base_reg    <= '0;
            done_reg    <= 1'b0;
            count_reg   <= '0;
            status_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            decay_reg   <= decay_next;
            seconds_reg <= seconds_next;
            fill_reg    <= fill_next;
            idx_reg     <= idx_next;
            op_reg      <= op_next;
            key_reg     <= key_next;
            work_reg    <= work_next;
            elapsed_reg <= elapsed_next;
            power_reg   <= power_next;
            base_reg    <= base_next;
            done_reg    <= done_next;
            count_reg   <= count_next;
            status_reg  <= status_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign count  = count_reg;
    assign status = status_reg;

endmodule

`default_nettype wire
